// ----- design/hasa_pkg.sv -----
package hasa_pkg;
    localparam int PARTY_COUNT = 6;
    localparam int MAX_SEATS   = 63;
    localparam int VOTE_W      = 24;
    localparam int SEAT_IN_W   = 6;
    localparam int SEAT_OUT_W  = 6;
    localparam int PARTY_W     = $clog2(PARTY_COUNT);
    localparam int DIV_STEP_W  = $clog2(VOTE_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_CMP,
        ST_AWARD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic compare;
        logic next_party;
        logic award;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic party_last;
        logic seats_done;
    } t_status;
endpackage

// ----- design/hasa_datapath.sv -----
module hasa_datapath
    import hasa_pkg::*;
#(
    parameter int MaxSeats = MAX_SEATS
) (
    input  logic                              i_clk,
    input  t_cmd                              i_cmd,
    input  logic [PARTY_COUNT-1:0][VOTE_W-1:0] i_votes,
    input  logic [SEAT_IN_W-1:0]              i_seats,
    output t_status                           o_status,
    output logic [PARTY_COUNT-1:0][SEAT_OUT_W-1:0] o_won
);
    localparam int SeatCntW = $clog2(MaxSeats + 1);
    localparam int DivW     = SeatCntW + 1;

    logic [PARTY_COUNT-1:0][VOTE_W-1:0] r_votes;
    logic [PARTY_COUNT-1:0][SeatCntW-1:0] r_won;
    logic [SeatCntW-1:0] r_left;
    logic [PARTY_W-1:0]  r_party, r_best;
    logic [VOTE_W-1:0]   r_best_q;
    // restoring divider
    logic [VOTE_W-1:0]   r_quo;
    logic [DivW-1:0]     r_rem;
    logic [DIV_STEP_W-1:0] r_step;

    logic [DivW-1:0]   divisor;
    logic [DivW:0]     trial;
    logic [DivW:0]     diff;
    logic [VOTE_W-1:0] quo_next;
    logic [SeatCntW-1:0] seats_sat;

    always_comb begin
        divisor  = DivW'(r_won[r_party]) + DivW'(1);
        trial    = {r_rem, r_quo[VOTE_W-1]};
        diff     = trial - {1'b0, divisor};
        quo_next = {r_quo[VOTE_W-2:0], ~diff[DivW]};
        if (32'(i_seats) > 32'(MaxSeats)) begin
            seats_sat = SeatCntW'(MaxSeats);
        end else begin
            seats_sat = SeatCntW'(i_seats);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_votes <= i_votes;
            r_won   <= '0;
            r_left  <= seats_sat;
            r_party <= '0;
        end
        if (i_cmd.div_start) begin
            r_quo  <= r_votes[r_party];
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_quo  <= quo_next;
            r_rem  <= diff[DivW] ? trial[DivW-1:0] : diff[DivW-1:0];
            r_step <= r_step + DIV_STEP_W'(1);
        end
        if (i_cmd.compare) begin
            if (r_party == '0 || r_quo > r_best_q) begin
                r_best_q <= r_quo;
                r_best   <= r_party;
            end
        end
        if (i_cmd.next_party) begin
            r_party <= (r_party == PARTY_W'(PARTY_COUNT - 1)) ? '0 : r_party + PARTY_W'(1);
        end
        if (i_cmd.award) begin
            r_won[r_best] <= r_won[r_best] + SeatCntW'(1);
            r_left        <= r_left - SeatCntW'(1);
        end
    end

    always_comb begin
        o_status.div_last   = (r_step == DIV_STEP_W'(VOTE_W - 1));
        o_status.party_last = (r_party == PARTY_W'(PARTY_COUNT - 1));
        o_status.seats_done = (r_left == '0);
        for (int p = 0; p < PARTY_COUNT; p++) begin
            o_won[p] = SEAT_OUT_W'(r_won[p]);
        end
    end
endmodule

// ----- design/hasa_ctrl.sv -----
module hasa_ctrl
    import hasa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_LOAD;
            ST_LOAD:  n_state = i_status.seats_done ? ST_DONE : ST_DIV;
            ST_DIV:   if (i_status.div_last) n_state = ST_CMP;
            // reload the divider for the next party, or close the seat round
            ST_CMP:   n_state = i_status.party_last ? ST_AWARD : ST_LOAD;
            ST_AWARD: n_state = ST_LOAD;
            ST_DONE:  if (i_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_LOAD: o_cmd.div_start = 1'b1;
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_CMP: begin
                o_cmd.compare    = 1'b1;
                o_cmd.next_party = 1'b1;
            end
            ST_AWARD: o_cmd.award = 1'b1;
            ST_DONE:  o_valid = 1'b1;
            default: ;
        endcase
        o_cmd.load = (r_state == ST_IDLE) && i_valid;
    end
endmodule

// ----- design/highest_averages_seat_allocator.sv -----
// Throughput: one district at a time; each seat round divides the six parties one after
// another in a shared restoring divider, one quotient bit per cycle.
// Next district is accepted in the cycle after the result word has been taken.
// Reset (synchronous, active low) returns the controller to idle; no result is pending.
module highest_averages_seat_allocator
    import hasa_pkg::*;
#(
    parameter int MaxSeats = MAX_SEATS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VOTE_W-1:0]     i_votes_party0,
    input  logic [VOTE_W-1:0]     i_votes_party1,
    input  logic [VOTE_W-1:0]     i_votes_party2,
    input  logic [VOTE_W-1:0]     i_votes_party3,
    input  logic [VOTE_W-1:0]     i_votes_party4,
    input  logic [VOTE_W-1:0]     i_votes_party5,
    input  logic [SEAT_IN_W-1:0]  i_seats_to_fill,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [SEAT_OUT_W-1:0] o_seats_party0,
    output logic [SEAT_OUT_W-1:0] o_seats_party1,
    output logic [SEAT_OUT_W-1:0] o_seats_party2,
    output logic [SEAT_OUT_W-1:0] o_seats_party3,
    output logic [SEAT_OUT_W-1:0] o_seats_party4,
    output logic [SEAT_OUT_W-1:0] o_seats_party5
);
    t_cmd    cmd;
    t_status status;
    logic [PARTY_COUNT-1:0][VOTE_W-1:0]     votes;
    logic [PARTY_COUNT-1:0][SEAT_OUT_W-1:0] won;

    assign votes = {i_votes_party5, i_votes_party4, i_votes_party3,
                    i_votes_party2, i_votes_party1, i_votes_party0};

    hasa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    hasa_datapath #(.MaxSeats(MaxSeats)) u_dp (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_votes  (votes),
        .i_seats  (i_seats_to_fill),
        .o_status (status),
        .o_won    (won)
    );

    assign o_seats_party0 = won[0];
    assign o_seats_party1 = won[1];
    assign o_seats_party2 = won[2];
    assign o_seats_party3 = won[3];
    assign o_seats_party4 = won[4];
    assign o_seats_party5 = won[5];
endmodule

// ----- test/tb.sv -----
module tb;
    import hasa_pkg::*;

    typedef struct packed {
        logic [PARTY_COUNT-1:0][VOTE_W-1:0] votes;
        logic [SEAT_IN_W-1:0]               seats;
    } t_district;

    typedef logic [PARTY_COUNT-1:0][SEAT_OUT_W-1:0] t_award;

    localparam int CYCLE_LIMIT = 12_000_000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [VOTE_W-1:0]     i_votes_party0, i_votes_party1, i_votes_party2;
    logic [VOTE_W-1:0]     i_votes_party3, i_votes_party4, i_votes_party5;
    logic [SEAT_IN_W-1:0]  i_seats_to_fill;
    logic                  o_valid;
    logic                  i_ready;
    logic [SEAT_OUT_W-1:0] o_seats_party0, o_seats_party1, o_seats_party2;
    logic [SEAT_OUT_W-1:0] o_seats_party3, o_seats_party4, o_seats_party5;

    highest_averages_seat_allocator u_dut (.*);

    t_district district_q[$];
    t_award    award_q[$];
    int        fail_count;
    int        cycle_count;
    int        idle_left;
    int        stall_left;
    bit        stim_done;
    bit        hold_for_drain;

    initial begin
        i_clk = 1'b0;
        forever begin
            #6 i_clk = 1'b1;
            #6 i_clk = 1'b0;
        end
    end

    // D'Hondt: each seat goes to the lowest-index party with the largest votes/divisor
    function automatic t_award dhondt_award(t_district d);
        t_award won;
        int     divisor[PARTY_COUNT];
        int     seats;
        int     best;
        logic [VOTE_W-1:0] best_q, q;
        won = '0;
        for (int p = 0; p < PARTY_COUNT; p++) divisor[p] = 1;
        seats = (d.seats > MAX_SEATS) ? MAX_SEATS : int'(d.seats);
        for (int s = 0; s < seats; s++) begin
            best = 0;
            best_q = VOTE_W'(d.votes[0] / divisor[0]);
            for (int p = 1; p < PARTY_COUNT; p++) begin
                q = VOTE_W'(d.votes[p] / divisor[p]);
                if (q > best_q) begin
                    best_q = q;
                    best = p;
                end
            end
            won[best] = won[best] + 1'b1;
            divisor[best]++;
        end
        return won;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 5) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    function automatic logic [VOTE_W-1:0] rand_votes();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return VOTE_W'($urandom_range(0, 50));
            3: return VOTE_W'($urandom_range(0, 5000));
            default: return VOTE_W'($urandom());
        endcase
    endfunction

    task automatic push_district(logic [PARTY_COUNT-1:0][VOTE_W-1:0] v, int seats);
        t_district d;
        d.votes = v;
        d.seats = SEAT_IN_W'(seats);
        district_q.push_back(d);
    endtask

    initial begin
        logic [PARTY_COUNT-1:0][VOTE_W-1:0] v;
        // directed: zero seats, max seats, all zero, all max, ties, a single party with votes
        push_district('0, 0);
        push_district('0, 63);
        push_district('1, 63);
        push_district('1, 0);
        push_district({6{24'd100}}, 12);
        push_district({24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd6}, 21);
        push_district({24'd6, 24'd5, 24'd4, 24'd3, 24'd2, 24'd1}, 21);
        push_district({24'hFFFFFF, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0}, 63);
        push_district({24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd7}, 10);
        push_district({24'd340000, 24'd280000, 24'd160000, 24'd60000, 24'd15000,
                       24'd5000}, 7);
        push_district({24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
                       24'h555555}, 1);
        push_district({24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555,
                       24'hAAAAAA}, 42);
        push_district({24'd10, 24'd20, 24'd20, 24'd10, 24'd0, 24'd30}, 9);
        for (int i = 0; i < 370; i++) begin
            for (int p = 0; p < PARTY_COUNT; p++) v[p] = rand_votes();
            push_district(v, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                          : $urandom_range(0, 16));
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            idle_left <= gap_len();
        end else begin
            if (i_valid && o_ready) begin
                award_q.push_back(dhondt_award(district_q.pop_front()));
                if (district_q.size() == 300) hold_for_drain <= 1'b1;
            end
            if (!(i_valid && !o_ready)) begin
                if (idle_left > 0 && !(i_valid && o_ready)) begin
                    i_valid   <= 1'b0;
                    idle_left <= idle_left - 1;
                end else if (hold_for_drain && award_q.size() > 0) begin
                    i_valid <= 1'b0;
                end else if (district_q.size() > 0 && !(i_valid && o_ready)) begin
                    hold_for_drain  <= 1'b0;
                    i_valid         <= 1'b1;
                    i_votes_party0  <= district_q[0].votes[0];
                    i_votes_party1  <= district_q[0].votes[1];
                    i_votes_party2  <= district_q[0].votes[2];
                    i_votes_party3  <= district_q[0].votes[3];
                    i_votes_party4  <= district_q[0].votes[4];
                    i_votes_party5  <= district_q[0].votes[5];
                    i_seats_to_fill <= district_q[0].seats;
                end else begin
                    // word just taken or no district left: drop valid, start a fresh gap
                    i_valid   <= 1'b0;
                    idle_left <= gap_len();
                    if (district_q.size() == 0) stim_done <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_award want;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= gap_len();
        end else begin
            if (o_valid && i_ready) begin
                if (award_q.size() == 0) begin
                    $error("result word with no district pending");
                    fail_count++;
                end else begin
                    want = award_q.pop_front();
                    if (o_seats_party0 !== want[0]) begin
                        $error("seats_party0 exp %0d got %0d", want[0], o_seats_party0);
                        fail_count++;
                    end
                    if (o_seats_party1 !== want[1]) begin
                        $error("seats_party1 exp %0d got %0d", want[1], o_seats_party1);
                        fail_count++;
                    end
                    if (o_seats_party2 !== want[2]) begin
                        $error("seats_party2 exp %0d got %0d", want[2], o_seats_party2);
                        fail_count++;
                    end
                    if (o_seats_party3 !== want[3]) begin
                        $error("seats_party3 exp %0d got %0d", want[3], o_seats_party3);
                        fail_count++;
                    end
                    if (o_seats_party4 !== want[4]) begin
                        $error("seats_party4 exp %0d got %0d", want[4], o_seats_party4);
                        fail_count++;
                    end
                    if (o_seats_party5 !== want[5]) begin
                        $error("seats_party5 exp %0d got %0d", want[5], o_seats_party5);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                i_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                i_ready <= 1'b1;
                if (o_valid && i_ready) stall_left <= gap_len();
            end
        end
    end

    initial begin
        fail_count      = 0;
        cycle_count     = 0;
        stim_done       = 1'b0;
        hold_for_drain  = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_ready         = 1'b0;
        i_votes_party0  = '0;
        i_votes_party1  = '0;
        i_votes_party2  = '0;
        i_votes_party3  = '0;
        i_votes_party4  = '0;
        i_votes_party5  = '0;
        i_seats_to_fill = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(stim_done && award_q.size() == 0) && cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            repeat (200) @(posedge i_clk);
            if (fail_count == 0 && award_q.size() == 0) begin
                $display("ALL CHECKS PASSED");
            end else begin
                $display("CHECKS FAILED");
            end
            $finish;
        end
    end
endmodule
